@@ src/aesctr_pkg.sv @@
`timescale 1ns / 1ps
package aesctr_pkg;

   localparam int unsigned BlockBits = 128;
   localparam int unsigned WordBits  = 64;
   localparam int unsigned CountBits = 5;
   localparam int unsigned Rounds    = 10;
   localparam int unsigned QueueDepth = 2;

   typedef enum logic [1:0] {
      CSR_KEY_HIGH   = 2'd0,
      CSR_KEY_LOW    = 2'd1,
      CSR_START_HIGH = 2'd2,
      CSR_START_LOW  = 2'd3
   } csr_index_type;

   // item handed from front to back: keystream input (counter), data and byte count
   typedef struct packed {
      logic [BlockBits-1:0] ctr;
      logic [BlockBits-1:0] data;
      logic [CountBits-1:0] count;
   } job_type;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type Sbox = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit block sits at bits 127-8i : 120-8i
   function automatic logic [7:0] get_byte(input logic [BlockBits-1:0] v, input int i);
      get_byte = v[BlockBits-1-8*i -: 8];
   endfunction

endpackage

@@ src/aesctr_if.sv @@
`timescale 1ns / 1ps
interface aesctr_req_if;
   logic        valid;
   logic        ready;
   logic        restart;
   logic [63:0] data_high;
   logic [63:0] data_low;
   logic [4:0]  byte_count;
   modport source (output valid, restart, data_high, data_low, byte_count, input ready);
   modport sink   (input valid, restart, data_high, data_low, byte_count, output ready);
endinterface

interface aesctr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_high;
   logic [63:0] out_low;
   logic [4:0]  out_count;
   modport source (output valid, out_high, out_low, out_count, input ready);
   modport sink   (input valid, out_high, out_low, out_count, output ready);
endinterface

@@ src/aesctr_front.sv @@
`timescale 1ns / 1ps
module aesctr_front (
   input  logic                          clock,
   input  logic                          reset,
   aesctr_req_if.sink                    req,
   input  logic [aesctr_pkg::BlockBits-1:0] start_count,
   input  logic                          q_ready,
   output logic                          q_valid,
   output aesctr_pkg::job_type           q_job
);
   import aesctr_pkg::*;

   logic [BlockBits-1:0] counter_ff, counter_in, ctr_now;
   logic [CountBits-1:0] count_sat;

   assign req.ready = q_ready;
   assign q_valid   = req.valid;
   assign ctr_now   = req.restart ? start_count : counter_ff;
   assign count_sat = (req.byte_count > CountBits'(16)) ? CountBits'(16) : req.byte_count;

   assign q_job.ctr   = ctr_now;
   assign q_job.data  = {req.data_high, req.data_low};
   assign q_job.count = count_sat;

   assign counter_in = ctr_now + BlockBits'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else if (req.valid && q_ready) begin
         counter_ff <= counter_in;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_adv: assert property (@(posedge clock) disable iff (reset)
      (req.valid && q_ready) |=> counter_ff == $past(counter_in))
      else $error("counter did not advance");
   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      !(req.valid && q_ready) |=> $stable(counter_ff))
      else $error("counter moved without item");
   a_count_rng: assert property (@(posedge clock) q_valid |-> q_job.count <= CountBits'(16))
      else $error("count not saturated");
`endif
endmodule

@@ src/aesctr_queue.sv @@
`timescale 1ns / 1ps
module aesctr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   output logic                wr_ready,
   input  aesctr_pkg::job_type wr_job,
   output logic                rd_valid,
   input  logic                rd_ready,
   output aesctr_pkg::job_type rd_job
);
   import aesctr_pkg::*;

   job_type    slot_ff [QueueDepth];
   logic [0:0] wptr_ff, rptr_ff;
   logic [1:0] fill_ff;
   logic       push, pop;

   assign wr_ready = fill_ff != 2'(QueueDepth);
   assign rd_valid = fill_ff != 2'd0;
   assign rd_job   = slot_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop)  rptr_ff <= rptr_ff + 1'b1;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

`ifndef ASSERT_OFF
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'(QueueDepth))
      else $error("queue overfilled");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd0 || fill_ff == 2'(QueueDepth)) |-> wptr_ff == rptr_ff)
      else $error("queue pointers out of step");
   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> fill_ff == $past(fill_ff) + 2'd1)
      else $error("fill count wrong");
`endif
endmodule

@@ src/aesctr_back.sv @@
`timescale 1ns / 1ps
module aesctr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [aesctr_pkg::BlockBits-1:0] key,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  aesctr_pkg::job_type           q_job,
   aesctr_rsp_if.source                  rsp
);
   import aesctr_pkg::*;

   logic                 busy_ff, busy_in;
   logic [3:0]           round_ff, round_in;
   logic [BlockBits-1:0] st_ff, st_in, rk_ff, rk_in;
   logic [BlockBits-1:0] data_ff;
   logic [CountBits-1:0] count_ff;
   logic [7:0]           rcon_ff, rcon_in;
   logic                 ov_ff, ov_in;
   logic [BlockBits-1:0] oval_ff, oval_in;
   logic [CountBits-1:0] ocnt_ff, ocnt_in;
   logic [BlockBits-1:0] sr, mc, nrk, ks, res;
   logic [31:0]          t;
   logic                 start, done;

   // round datapath: SubBytes, ShiftRows, MixColumns (not last round), key schedule
   always_comb begin
      logic [7:0] a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            sr[BlockBits-1-8*(i+4*c) -: 8] = Sbox[get_byte(st_ff, i + 4*((c+i) & 3))];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(sr, 4*c);
         a1 = get_byte(sr, 4*c+1);
         a2 = get_byte(sr, 4*c+2);
         a3 = get_byte(sr, 4*c+3);
         al = a0 ^ a1 ^ a2 ^ a3;
         mc[BlockBits-1-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                        a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
      end
      t = {Sbox[get_byte(rk_ff, 13)] ^ rcon_ff, Sbox[get_byte(rk_ff, 14)],
           Sbox[get_byte(rk_ff, 15)], Sbox[get_byte(rk_ff, 12)]};
      nrk[127:96] = rk_ff[127:96] ^ t;
      nrk[95:64]  = rk_ff[95:64] ^ nrk[127:96];
      nrk[63:32]  = rk_ff[63:32] ^ nrk[95:64];
      nrk[31:0]   = rk_ff[31:0] ^ nrk[63:32];
   end

   assign ks   = ((round_ff == 4'(Rounds)) ? sr : mc) ^ nrk;
   assign done = busy_ff && (round_ff == 4'(Rounds)) && (!ov_ff || rsp.ready);

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         res[BlockBits-1-8*i -: 8] = (CountBits'(i) < count_ff)
            ? (get_byte(data_ff, i) ^ get_byte(ks, i)) : 8'h00;
      end
   end

   assign q_ready = !busy_ff || done;
   assign start   = q_valid && q_ready;

   always_comb begin
      busy_in  = busy_ff;
      round_in = round_ff;
      st_in    = st_ff;
      rk_in    = rk_ff;
      rcon_in  = rcon_ff;
      ov_in    = ov_ff && !rsp.ready;
      oval_in  = oval_ff;
      ocnt_in  = ocnt_ff;
      if (busy_ff && round_ff != 4'(Rounds)) begin
         st_in    = mc ^ nrk;
         rk_in    = nrk;
         rcon_in  = xtime(rcon_ff);
         round_in = round_ff + 4'd1;
      end
      if (done) begin
         busy_in = 1'b0;
         ov_in   = 1'b1;
         oval_in = res;
         ocnt_in = count_ff;
      end
      if (start) begin
         busy_in  = 1'b1;
         round_in = 4'd1;
         st_in    = q_job.ctr ^ key;
         rk_in    = key;
         rcon_in  = 8'h01;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in;
      st_ff    <= st_in;
      rk_ff    <= rk_in;
      rcon_ff  <= rcon_in;
      oval_ff  <= oval_in;
      ocnt_ff  <= ocnt_in;
      if (start) begin
         data_ff  <= q_job.data;
         count_ff <= q_job.count;
      end
   end

   assign rsp.valid     = ov_ff;
   assign rsp.out_high  = oval_ff[127:64];
   assign rsp.out_low   = oval_ff[63:0];
   assign rsp.out_count = ocnt_ff;

`ifndef ASSERT_OFF
   a_round_rng: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (round_ff >= 4'd1 && round_ff <= 4'(Rounds)))
      else $error("round out of range");
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !rsp.ready) |=> ov_ff && $stable(oval_ff))
      else $error("pending result overwritten");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (!busy_ff || done))
      else $error("start while busy");
`endif
endmodule

@@ src/aes128_counter_mode_crypt_unit.sv @@
`timescale 1ns / 1ps
// An accepted req goes through the queue, key add, ten rounds and result register to rsp.
// The back end's single iterated round unit starts an item only when the last is done.
// A two-entry queue decouples the front (counter update) from the round unit; the
// result register lets the next item start while a finished one waits.
// Reset: synchronous active high; clears CSRs, counter, queue pointers, busy/valid flags.
module aes128_counter_mode_crypt_unit (
   input  logic        clock,
   input  logic        reset,
   aesctr_req_if.sink  req,
   aesctr_rsp_if.source rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   import aesctr_pkg::*;

   logic [WordBits-1:0] key_high_ff, key_low_ff, start_high_ff, start_low_ff;
   logic    fq_valid, fq_ready, bq_valid, bq_ready;
   job_type fq_job, bq_job;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         start_high_ff <= '0;
         start_low_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_HIGH:   key_high_ff   <= csr_write_data;
            CSR_KEY_LOW:    key_low_ff    <= csr_write_data;
            CSR_START_HIGH: start_high_ff <= csr_write_data;
            CSR_START_LOW:  start_low_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // front: counter select and advance, byte count clamp
   aesctr_front u_front (
      .clock, .reset, .req,
      .start_count({start_high_ff, start_low_ff}),
      .q_ready(fq_ready), .q_valid(fq_valid), .q_job(fq_job)
   );

   aesctr_queue u_queue (
      .clock, .reset,
      .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
      .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_job(bq_job)
   );

   // back: iterated AES round, keystream XOR, output register
   aesctr_back u_back (
      .clock, .reset,
      .key({key_high_ff, key_low_ff}),
      .q_valid(bq_valid), .q_ready(bq_ready), .q_job(bq_job),
      .rsp
   );
endmodule
